// ===== hdl/qtue_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the Q table update engine: field widths, stream packing,
// register indexes and default parameter values. No dependencies.

package qtue_pkg;

    // Default table geometry and value width
    localparam int NUM_STATES_DEF  = 64;
    localparam int NUM_ACTIONS_DEF = 4;
    localparam int VALUE_WIDTH_DEF = 32;

    // Input item fields
    localparam int STATE_FW  = 6;
    localparam int ACTION_FW = 2;
    localparam int REWARD_FW = 32;

    // Result item fields
    localparam int NEW_VALUE_FW = 32;
    localparam int SUM_W        = 48;
    localparam int GREEDY_FW    = 2;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 2 * STATE_FW + 2 * ACTION_FW + REWARD_FW;
    localparam int M_TDATA_RAW = NEW_VALUE_FW + SUM_W + GREEDY_FW;
    localparam int M_TDATA_W = ((M_TDATA_RAW + 7) / 8) * 8;

    // Fixed-point coefficients: 16 fraction bits, 65536 means one
    localparam int          COEF_W     = 17;
    localparam int          FRAC_W     = 16;
    localparam logic [16:0] COEF_ONE   = 17'd65536;
    localparam logic [16:0] ALPHA_RST  = 17'd6554;
    localparam logic [16:0] GAMMA_RST  = 17'd65536;
    localparam logic [15:0] ROUND_HALF = 16'd32768;

    // Configuration port
    localparam int          CFG_IDX_W         = 2;
    localparam logic [1:0]  CFG_LEARNING_RATE = 2'd0;
    localparam logic [1:0]  CFG_DISCOUNT      = 2'd1;
    localparam logic [1:0]  CFG_RULE_MODE     = 2'd2;

    // Update rule codes
    localparam logic MODE_QLEARN = 1'b0;
    localparam logic MODE_SARSA  = 1'b1;

endpackage

// ===== hdl/q_table_update_engine.sv =====
`timescale 1ns / 1ps
// Q table update engine top level: control sequencer, registers and stream ports.
// Depends on qtue_pkg, qtue_table, qtue_argmax and qtue_scale.

// Each accepted beat is one transition (state, action, next state, next action,
// reward). The engine reads the current and next state rows of its Q table in the same
// cycle, picks the greedy next action, forms Q + alpha*(r + gamma*Qnext - Q) with
// round-half-away scaling and saturation, writes it back and adds it to a
// saturating 48-bit running sum. In rule mode 0 Qnext is the largest Q of the next
// state (Q-learning); in mode 1 it is the Q of the given next action (SARSA).
// One transition is in flight at a time. After acceptance the sequencer loads both
// rows, scales gamma*Qnext, forms the difference, scales it by alpha and writes back;
// both coefficient products run through one shared scaler that splits the magnitude
// in two halves. The result waits in an output register, so the next transition is
// accepted while it is unread; only its own write-back holds until the register is
// free.
// After reset the table is cleared one row per cycle, and no transition is accepted
// until every row is cleared; configuration writes are taken at any time.
// States and actions beyond the table are reduced modulo NUM_STATES and
// NUM_ACTIONS; coefficients above one are used as one.

module q_table_update_engine #(
    parameter int NUM_STATES  = qtue_pkg::NUM_STATES_DEF,
    parameter int NUM_ACTIONS = qtue_pkg::NUM_ACTIONS_DEF,
    parameter int VALUE_WIDTH = qtue_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // cur_state[5:0], cur_action[7:6], next_state[13:8], next_action[15:14],
    // reward[47:16]
    input  logic [qtue_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // new_value[31:0], value_sum[79:32], greedy_action[81:80], zero pad above
    output logic [qtue_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic                              i_cfg_wr_en,
    input  logic [qtue_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qtue_pkg::COEF_W-1:0]       i_cfg_data
);

    localparam int VW    = VALUE_WIDTH;
    localparam int SW    = $clog2(NUM_STATES);
    localparam int AW    = $clog2(NUM_ACTIONS);
    localparam int ROW_W = NUM_ACTIONS * VW;
    localparam int XW    = VW + 1;                       // difference width
    localparam int TW    = ((VW > 32) ? VW : 32) + 1;    // reward + scaled
    localparam int NW    = XW + 1;                       // Q + scaled diff
    localparam int SUMW  = qtue_pkg::SUM_W;
    localparam int NST_F = 1 << qtue_pkg::STATE_FW;
    localparam int NAC_F = 1 << qtue_pkg::ACTION_FW;

    localparam logic signed [VW-1:0]   V_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0]   V_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [SUMW-1:0] S_MAX = {1'b0, {(SUMW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] S_MIN = {1'b1, {(SUMW-1){1'b0}}};

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_LOAD  = 4'd2;
    localparam logic [3:0] ST_GAMMA = 4'd3;
    localparam logic [3:0] ST_GWAIT = 4'd4;
    localparam logic [3:0] ST_DIFF  = 4'd5;
    localparam logic [3:0] ST_ALPHA = 4'd6;
    localparam logic [3:0] ST_AWAIT = 4'd7;
    localparam logic [3:0] ST_WB    = 4'd8;

    // ---------------------------------------------------------------- fields
    logic [qtue_pkg::STATE_FW-1:0]  f_cur_state;
    logic [qtue_pkg::ACTION_FW-1:0] f_cur_action;
    logic [qtue_pkg::STATE_FW-1:0]  f_next_state;
    logic [qtue_pkg::ACTION_FW-1:0] f_next_action;
    logic signed [qtue_pkg::REWARD_FW-1:0] f_reward;

    assign f_cur_state   = i_s_tdata[5:0];
    assign f_cur_action  = i_s_tdata[7:6];
    assign f_next_state  = i_s_tdata[13:8];
    assign f_next_action = i_s_tdata[15:14];
    assign f_reward      = i_s_tdata[47:16];

    // Constant modulo tables for the narrow state and action fields
    logic [SW-1:0] st_mod [NST_F];
    logic [AW-1:0] ac_mod [NAC_F];

    for (genvar v = 0; v < NST_F; v++) begin : g_st_mod
        assign st_mod[v] = SW'(v % NUM_STATES);
    end
    for (genvar v = 0; v < NAC_F; v++) begin : g_ac_mod
        assign ac_mod[v] = AW'(v % NUM_ACTIONS);
    end

    // ---------------------------------------------------------------- registers
    logic [3:0]                  r_state;
    logic [SW-1:0]               r_clr;
    logic [qtue_pkg::COEF_W-1:0] r_alpha;
    logic [qtue_pkg::COEF_W-1:0] r_gamma;
    logic                        r_mode;
    logic signed [SUMW-1:0]      r_sum;
    logic                        r_m_valid;

    logic [SW-1:0]               r_cur_row;
    logic [AW-1:0]               r_cur_a;
    logic [AW-1:0]               r_nxt_a;
    logic signed [qtue_pkg::REWARD_FW-1:0] r_reward;
    logic [ROW_W-1:0]            r_cur_data;
    logic signed [VW-1:0]        r_q;
    logic signed [VW-1:0]        r_qnext;
    logic [AW-1:0]               r_greedy;
    logic signed [VW-1:0]        r_target;
    logic signed [XW-1:0]        r_diff;
    logic signed [VW-1:0]        r_nq;
    logic [qtue_pkg::M_TDATA_W-1:0] r_m_data;

    logic s_accept;
    logic wb_go;
    assign s_accept = i_s_tvalid && o_s_tready;
    assign wb_go    = (r_state == ST_WB) && (!r_m_valid || i_m_tready);

    // ---------------------------------------------------------------- table
    logic             mem_we;
    logic [SW-1:0]    mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic [ROW_W-1:0] rd_cur;
    logic [ROW_W-1:0] rd_nxt;
    logic [ROW_W-1:0] wb_row;

    always_comb begin
        wb_row = r_cur_data;
        wb_row[r_cur_a*VW +: VW] = r_nq;
    end

    // Clear rows after reset, otherwise write back the updated row
    assign mem_we    = (r_state == ST_CLEAR) || wb_go;
    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr : r_cur_row;
    assign mem_wdata = (r_state == ST_CLEAR) ? '0 : wb_row;

    qtue_table #(
        .ROWS  (NUM_STATES),
        .ROW_W (ROW_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (mem_we),
        .i_wr_addr   (mem_waddr),
        .i_wr_data   (mem_wdata),
        .i_rd_addr_a (st_mod[f_cur_state]),
        .i_rd_addr_b (st_mod[f_next_state]),
        .o_rd_data_a (rd_cur),
        .o_rd_data_b (rd_nxt)
    );

    // ---------------------------------------------------------------- greedy
    logic signed [VW-1:0] best_val;
    logic [AW-1:0]        best_idx;

    qtue_argmax #(
        .NUM_ACTIONS (NUM_ACTIONS),
        .VALUE_WIDTH (VW)
    ) u_argmax (
        .i_row  (rd_nxt),
        .o_best (best_val),
        .o_idx  (best_idx)
    );

    // ---------------------------------------------------------------- scaler
    logic                        scl_start;
    logic [qtue_pkg::COEF_W-1:0] scl_coef;
    logic signed [XW-1:0]        scl_x;
    logic                        scl_done;
    logic signed [XW-1:0]        scl_res;

    // One scaler serves gamma*Qnext first, then alpha*difference
    assign scl_start = (r_state == ST_GAMMA) || (r_state == ST_ALPHA);
    assign scl_coef  = (r_state == ST_ALPHA) ? r_alpha : r_gamma;
    assign scl_x     = (r_state == ST_ALPHA) ? r_diff : XW'(r_qnext);

    qtue_scale #(
        .XW (XW)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scl_start),
        .i_coef  (scl_coef),
        .i_x     (scl_x),
        .o_done  (scl_done),
        .o_res   (scl_res)
    );

    // ---------------------------------------------------------------- arithmetic
    logic signed [TW-1:0]   tgt_sum;
    logic signed [VW-1:0]   n_target;
    logic signed [NW-1:0]   nq_sum;
    logic signed [VW-1:0]   n_nq;
    logic signed [SUMW:0]   acc_sum;
    logic signed [SUMW-1:0] n_sum;
    logic signed [63:0]     nq_ext;

    always_comb begin
        tgt_sum = TW'(r_reward) + TW'(scl_res);
        if (tgt_sum > TW'(V_MAX)) begin
            n_target = V_MAX;
        end else if (tgt_sum < TW'(V_MIN)) begin
            n_target = V_MIN;
        end else begin
            n_target = VW'(tgt_sum);
        end

        nq_sum = NW'(r_q) + NW'(scl_res);
        if (nq_sum > NW'(V_MAX)) begin
            n_nq = V_MAX;
        end else if (nq_sum < NW'(V_MIN)) begin
            n_nq = V_MIN;
        end else begin
            n_nq = VW'(nq_sum);
        end

        acc_sum = (SUMW+1)'(r_sum) + (SUMW+1)'(r_nq);
        if (acc_sum > (SUMW+1)'(S_MAX)) begin
            n_sum = S_MAX;
        end else if (acc_sum < (SUMW+1)'(S_MIN)) begin
            n_sum = S_MIN;
        end else begin
            n_sum = SUMW'(acc_sum);
        end

        nq_ext = 64'(r_nq);
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_alpha   <= qtue_pkg::ALPHA_RST;
            r_gamma   <= qtue_pkg::GAMMA_RST;
            r_mode    <= qtue_pkg::MODE_QLEARN;
            r_sum     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // Coefficients above one are stored as one
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    qtue_pkg::CFG_LEARNING_RATE:
                        r_alpha <= (i_cfg_data > qtue_pkg::COEF_ONE) ?
                                   qtue_pkg::COEF_ONE : i_cfg_data;
                    qtue_pkg::CFG_DISCOUNT:
                        r_gamma <= (i_cfg_data > qtue_pkg::COEF_ONE) ?
                                   qtue_pkg::COEF_ONE : i_cfg_data;
                    qtue_pkg::CFG_RULE_MODE:
                        r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // Load a new result, or drop the old one once it is taken
            if (wb_go) begin
                r_m_valid <= 1'b1;
                r_sum     <= n_sum;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + SW'(1);
                    if (r_clr == SW'(NUM_STATES - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE:  if (s_accept) r_state <= ST_LOAD;
                ST_LOAD:  r_state <= ST_GAMMA;
                ST_GAMMA: r_state <= ST_GWAIT;
                ST_GWAIT: if (scl_done) r_state <= ST_DIFF;
                ST_DIFF:  r_state <= ST_ALPHA;
                ST_ALPHA: r_state <= ST_AWAIT;
                ST_AWAIT: if (scl_done) r_state <= ST_WB;
                ST_WB:    if (wb_go) r_state <= ST_IDLE;
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cur_row <= st_mod[f_cur_state];
            r_cur_a   <= ac_mod[f_cur_action];
            r_nxt_a   <= ac_mod[f_next_action];
            r_reward  <= f_reward;
        end
        // Both rows arrive in the cycle after acceptance, before any write-back
        if (r_state == ST_LOAD) begin
            r_cur_data <= rd_cur;
            r_q        <= rd_cur[r_cur_a*VW +: VW];
            r_qnext    <= (r_mode == qtue_pkg::MODE_SARSA) ?
                          rd_nxt[r_nxt_a*VW +: VW] : best_val;
            r_greedy   <= best_idx;
        end
        if (r_state == ST_GWAIT && scl_done) begin
            r_target <= n_target;
        end
        if (r_state == ST_DIFF) begin
            r_diff <= XW'(r_target) - XW'(r_q);
        end
        if (r_state == ST_AWAIT && scl_done) begin
            r_nq <= n_nq;
        end
        if (wb_go) begin
            r_m_data <= qtue_pkg::M_TDATA_W'({qtue_pkg::GREEDY_FW'(r_greedy),
                                               n_sum,
                                               nq_ext[qtue_pkg::NEW_VALUE_FW-1:0]});
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // ---------------------------------------------------------------- checks
    // An accepted beat always moves straight into the row load
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_LOAD))
        else $error("accepted beat did not start a row load");

    // The scaler reports only while the sequencer waits for it
    a_scale_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scl_done |-> (r_state == ST_GWAIT || r_state == ST_AWAIT))
        else $error("scaler result arrived outside a wait state");

    // Write-back holds while the output register is still occupied
    a_wb_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB && r_m_valid && !i_m_tready) |=> (r_state == ST_WB))
        else $error("write-back overran an unread result");

    // The presented value is the one just written to the table
    a_out_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wb_go |=> (o_m_tvalid &&
                   o_m_tdata[qtue_pkg::NEW_VALUE_FW-1:0] ==
                   $past(nq_ext[qtue_pkg::NEW_VALUE_FW-1:0])))
        else $error("output value differs from written Q");

endmodule

// ===== hdl/qtue_table.sv =====
`timescale 1ns / 1ps
// Q table storage: one row per state holding every action's value.
// Two registered read ports and one write port. Uses no package items.

module qtue_table #(
    parameter int ROWS  = 64,
    parameter int ROW_W = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(ROWS)-1:0]  i_wr_addr,
    input  logic [ROW_W-1:0]         i_wr_data,
    input  logic [$clog2(ROWS)-1:0]  i_rd_addr_a,
    input  logic [$clog2(ROWS)-1:0]  i_rd_addr_b,
    output logic [ROW_W-1:0]         o_rd_data_a,
    output logic [ROW_W-1:0]         o_rd_data_b
);

    logic [ROW_W-1:0] r_mem [ROWS];
    logic [ROW_W-1:0] r_rd_a;
    logic [ROW_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== hdl/qtue_argmax.sv =====
`timescale 1ns / 1ps
// Greedy action search over one table row: a compare tree, lowest index wins ties.
// Uses no package items.

module qtue_argmax #(
    parameter int NUM_ACTIONS = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic [NUM_ACTIONS*VALUE_WIDTH-1:0]   i_row,
    output logic signed [VALUE_WIDTH-1:0]        o_best,
    output logic [$clog2(NUM_ACTIONS)-1:0]       o_idx
);

    localparam int AW = $clog2(NUM_ACTIONS);
    localparam int NP = 1 << AW;

    logic signed [VALUE_WIDTH-1:0] leaf_val [NP];
    logic                          leaf_vld [NP];

    logic signed [VALUE_WIDTH-1:0] t_val [AW+1][NP];
    logic [AW-1:0]                 t_idx [AW+1][NP];
    logic                          t_vld [AW+1][NP];

    // Pad the row to a power of two with leaves that never win
    for (genvar g = 0; g < NP; g++) begin : g_leaf
        if (g < NUM_ACTIONS) begin : g_real
            assign leaf_val[g] = i_row[g*VALUE_WIDTH +: VALUE_WIDTH];
            assign leaf_vld[g] = 1'b1;
        end else begin : g_pad
            assign leaf_val[g] = '0;
            assign leaf_vld[g] = 1'b0;
        end
    end

    always_comb begin
        for (int l = 0; l <= AW; l++) begin
            for (int n = 0; n < NP; n++) begin
                t_val[l][n] = '0;
                t_idx[l][n] = '0;
                t_vld[l][n] = 1'b0;
            end
        end
        for (int n = 0; n < NP; n++) begin
            t_val[0][n] = leaf_val[n];
            t_idx[0][n] = AW'(n);
            t_vld[0][n] = leaf_vld[n];
        end
        // Take the right side only when it is strictly larger
        for (int l = 0; l < AW; l++) begin
            for (int n = 0; n < (NP >> (l + 1)); n++) begin
                if (t_vld[l][2*n+1] &&
                    (!t_vld[l][2*n] || (t_val[l][2*n+1] > t_val[l][2*n]))) begin
                    t_val[l+1][n] = t_val[l][2*n+1];
                    t_idx[l+1][n] = t_idx[l][2*n+1];
                end else begin
                    t_val[l+1][n] = t_val[l][2*n];
                    t_idx[l+1][n] = t_idx[l][2*n];
                end
                t_vld[l+1][n] = t_vld[l][2*n] | t_vld[l][2*n+1];
            end
        end
    end

    assign o_best = t_val[AW][0];
    assign o_idx  = t_idx[AW][0];

endmodule

// ===== hdl/qtue_scale.sv =====
`timescale 1ns / 1ps
// Coefficient scaler: round(coef * x / 2^16), ties away from zero.
// The magnitude is multiplied in two halves. Depends on qtue_pkg.

module qtue_scale #(
    parameter int XW = 33
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [qtue_pkg::COEF_W-1:0]         i_coef,
    input  logic signed [XW-1:0]                i_x,
    output logic                                o_done,
    output logic signed [XW-1:0]                o_res
);

    localparam int LH = (XW + 1) / 2;
    localparam int HH = XW - LH;
    localparam int PW = qtue_pkg::COEF_W + XW;

    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_MLO  = 2'd1;
    localparam logic [1:0] STEP_MHI  = 2'd2;
    localparam logic [1:0] STEP_RND  = 2'd3;

    logic [1:0]                        r_step;
    logic                              r_done;
    logic                              r_neg;
    logic [XW-1:0]                     r_mag;
    logic [qtue_pkg::COEF_W-1:0]       r_coef;
    logic [qtue_pkg::COEF_W+LH-1:0]    r_plo;
    logic [qtue_pkg::COEF_W+HH-1:0]    r_phi;
    logic signed [XW-1:0]              r_res;

    logic [PW-1:0] prod;
    logic [PW:0]   rnd;
    logic [XW-1:0] mag_r;

    always_comb begin
        prod  = (PW'(r_phi) << LH) + PW'(r_plo);
        rnd   = (PW+1)'(prod) + (PW+1)'(qtue_pkg::ROUND_HALF);
        mag_r = rnd[qtue_pkg::FRAC_W +: XW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_step)
                STEP_IDLE: if (i_start) r_step <= STEP_MLO;
                STEP_MLO:  r_step <= STEP_MHI;
                STEP_MHI:  r_step <= STEP_RND;
                STEP_RND: begin
                    r_done <= 1'b1;
                    r_step <= STEP_IDLE;
                end
                default:   r_step <= STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == STEP_IDLE && i_start) begin
            r_neg  <= i_x[XW-1];
            r_mag  <= i_x[XW-1] ? (~i_x + XW'(1)) : i_x;
            r_coef <= i_coef;
        end
        if (r_step == STEP_MLO) begin
            r_plo <= r_coef * r_mag[LH-1:0];
        end
        if (r_step == STEP_MHI) begin
            r_phi <= r_coef * r_mag[XW-1:LH];
        end
        if (r_step == STEP_RND) begin
            r_res <= r_neg ? -signed'(mag_r) : signed'(mag_r);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== sim/q_table_update_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for q_table_update_engine: a scoreboard class keeps its own
// copy of the Q table, sum and coefficients and predicts every result beat.
// Depends on qtue_pkg and the engine RTL only.

module q_table_update_engine_tb;

    import qtue_pkg::*;

    localparam int          ACTIONS      = NUM_ACTIONS_DEF;
    localparam int          TABLE_DEPTH  = NUM_STATES_DEF * NUM_ACTIONS_DEF;
    localparam longint      VALUE_MAX    = 64'sd2147483647;
    localparam longint      VALUE_MIN    = -VALUE_MAX - 1;
    localparam longint      SUM_MAX      = (64'sd1 <<< 47) - 1;
    localparam longint      SUM_MIN      = -SUM_MAX - 1;
    localparam logic [1:0]  CFG_UNMAPPED = 2'd3;    // no register behind this index
    localparam int          STALL_LIMIT  = 4000;    // cycles without any beat moving
    localparam int          DRAIN_CYCLES = 40;      // write-back latency plus margin

    // Input beat layout, lowest field last (packed structs fill from the top down)
    typedef struct packed {
        logic signed [REWARD_FW-1:0] reward;
        logic [ACTION_FW-1:0]        next_action;
        logic [STATE_FW-1:0]         next_state;
        logic [ACTION_FW-1:0]        cur_action;
        logic [STATE_FW-1:0]         cur_state;
    } transition_t;

    // Output beat layout: new value lowest, then the running sum, greedy action, pad
    typedef struct packed {
        logic [M_TDATA_W-M_TDATA_RAW-1:0] pad;
        logic [GREEDY_FW-1:0]             greedy;
        logic [SUM_W-1:0]                 total;
        logic [NEW_VALUE_FW-1:0]          value;
    } q_result_t;

    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_LONG_STALL} rx_style_e;

    // Keeps the predicted Q table and the queue of results still owed by the engine
    class q_update_scoreboard;
        longint      value_table [TABLE_DEPTH];
        longint      running_sum;
        logic [16:0] alpha_reg;
        logic [16:0] gamma_reg;
        logic        rule_reg;
        q_result_t   queued_updates [$];
        int          mismatches;

        function void restart();
            foreach (value_table[i]) value_table[i] = 0;
            running_sum = 0;
            alpha_reg   = ALPHA_RST;
            gamma_reg   = GAMMA_RST;
            rule_reg    = MODE_QLEARN;
            mismatches  = 0;
            queued_updates.delete();
        endfunction

        function void apply_register(logic [1:0] idx, logic [16:0] data);
            case (idx)
                CFG_LEARNING_RATE: alpha_reg = data;
                CFG_DISCOUNT:      gamma_reg = data;
                CFG_RULE_MODE:     rule_reg  = data[0];
                default: ;
            endcase
        endfunction

        function int pending_count();
            return queued_updates.size();
        endfunction

        // round(coef * x / 2^16), halves away from zero
        function longint scale_coef(logic [16:0] coef, longint x);
            longint unsigned mag;
            longint unsigned rounded;
            mag = (x < 0) ? -x : x;
            rounded = (longint'(coef) * mag + ROUND_HALF) >> FRAC_W;
            return (x < 0) ? -longint'(rounded) : longint'(rounded);
        endfunction

        function longint saturate(longint x, longint lo, longint hi);
            if (x < lo) return lo;
            if (x > hi) return hi;
            return x;
        endfunction

        function void note_transition(transition_t t);
            int          cur_idx;
            int          next_base;
            longint      q;
            longint      best;
            longint      qnext;
            longint      target;
            longint      nq;
            logic [1:0]  best_a;
            logic [16:0] alpha;
            logic [16:0] gamma;
            q_result_t   r;
            cur_idx   = int'(t.cur_state) * ACTIONS + int'(t.cur_action);
            next_base = int'(t.next_state) * ACTIONS;
            alpha = (alpha_reg > COEF_ONE) ? COEF_ONE : alpha_reg;
            gamma = (gamma_reg > COEF_ONE) ? COEF_ONE : gamma_reg;
            // All reads see the table before this transition's write
            q      = value_table[cur_idx];
            best   = value_table[next_base];
            best_a = '0;
            for (int a = 1; a < ACTIONS; a++) begin
                if (value_table[next_base + a] > best) begin
                    best   = value_table[next_base + a];
                    best_a = 2'(a);
                end
            end
            qnext = (rule_reg == MODE_SARSA) ?
                    value_table[next_base + int'(t.next_action)] : best;
            target = saturate(longint'($signed(t.reward)) + scale_coef(gamma, qnext),
                              VALUE_MIN, VALUE_MAX);
            nq = saturate(q + scale_coef(alpha, target - q), VALUE_MIN, VALUE_MAX);
            value_table[cur_idx] = nq;
            running_sum = saturate(running_sum + nq, SUM_MIN, SUM_MAX);
            r        = '0;
            r.value  = nq[31:0];
            r.total  = running_sum[47:0];
            r.greedy = best_a;
            queued_updates.push_back(r);
        endfunction

        function void check_result(q_result_t got);
            q_result_t want;
            if (queued_updates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing outstanding: value %0d sum %0d greedy %0d",
                             $signed(got.value), $signed(got.total), got.greedy);
                return;
            end
            want = queued_updates.pop_front();
            if (got.value !== want.value || got.total !== want.total ||
                    got.greedy !== want.greedy) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: value exp %0d got %0d, sum exp %0d got %0d, %s%0d got %0d",
                             $time, $signed(want.value), $signed(got.value),
                             $signed(want.total), $signed(got.total),
                             "greedy exp ", want.greedy, got.greedy);
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [COEF_W-1:0]     i_cfg_data  = '0;

    q_update_scoreboard board;
    rx_style_e          rx_style    = RX_COIN;
    int unsigned        ready_hold  = 0;
    int unsigned        quiet_count = 0;
    logic [STATE_FW-1:0]  last_state  = '0;
    logic [ACTION_FW-1:0] last_action = '0;

    q_table_update_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: accept a beat whenever valid and ready meet at an edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(q_result_t'(o_m_tdata));
    end

    // Receiver back-pressure: always ready, coin flips, or long stalls with short
    // ready windows, depending on the phase
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case (rx_style)
                RX_STREAM: begin
                    i_m_tready <= 1'b1;
                end
                RX_COIN: begin
                    i_m_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    i_m_tready <= ~i_m_tready;
                    ready_hold <= i_m_tready ? $urandom_range(3, 40) : $urandom_range(0, 6);
                end
            endcase
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= STALL_LIMIT) begin
            $display("q_table_update_engine_tb failed");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    function automatic transition_t make_transition(
        input logic [5:0] cs, input logic [1:0] ca,
        input logic [5:0] ns, input logic [1:0] na, input logic [31:0] rw
    );
        transition_t t;
        t.cur_state   = cs;
        t.cur_action  = ca;
        t.next_state  = ns;
        t.next_action = na;
        t.reward      = rw;
        return t;
    endfunction

    // Random transition: mostly a few hot states so entries get revisited, and
    // often chained from the previous beat so reads hit the entry just written
    function automatic transition_t random_transition();
        transition_t t;
        logic [31:0] raw;
        t.cur_state   = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 7)) : 6'($urandom());
        t.cur_action  = 2'($urandom());
        t.next_state  = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 7)) : 6'($urandom());
        t.next_action = 2'($urandom());
        case ($urandom_range(0, 9))
            0: begin
                t.cur_state  = last_state;
                t.cur_action = last_action;
            end
            1: t.next_state = last_state;
            2: t.next_state = t.cur_state;
            default: ;
        endcase
        raw = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: t.reward = 32'($urandom_range(0, 262144)) - 32'd131072;
            4, 5:       t.reward = {{8{raw[23]}}, raw[23:0]};
            6, 7:       t.reward = raw;
            default: begin
                case ($urandom_range(0, 3))
                    0:       t.reward = 32'h7FFF_FFFF;
                    1:       t.reward = 32'h8000_0000;
                    2:       t.reward = '0;
                    default: t.reward = '1;
                endcase
            end
        endcase
        last_state  = t.cur_state;
        last_action = t.cur_action;
        return t;
    endfunction

    // Present one beat and hold it until the engine takes it; valid stays high
    task automatic send_transition(input transition_t t);
        i_s_tdata  <= t;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_transition(t);
    endtask

    // Drop valid and hold off until every predicted result has been taken
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending_count() != 0);
    endtask

    // Write all registers back to back, with a write to the unmapped index in between
    task automatic load_settings(input logic [16:0] alpha, input logic [16:0] gamma,
                                 input logic mode);
        logic [1:0]  idx [4];
        logic [16:0] val [4];
        idx = '{CFG_LEARNING_RATE, CFG_UNMAPPED, CFG_DISCOUNT, CFG_RULE_MODE};
        val = '{alpha, 17'($urandom()), gamma, {16'd0, mode}};
        for (int k = 0; k < 4; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            board.apply_register(idx[k], val[k]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // Random beats in bursts with random gaps; drain once halfway through
    task automatic send_random(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < count; j++) begin
                send_transition(random_transition());
                sent++;
                if (sent == count / 2)
                    wait_for_results();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        board = new;
        board.restart();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients, Q-learning: zero row ties, reward extremes, and the
        // same entry read and written by back-to-back beats
        send_transition(make_transition(6'd0,  2'd0, 6'd0,  2'd0, 32'h0000_0000));
        send_transition(make_transition(6'd63, 2'd3, 6'd63, 2'd3, 32'h7FFF_FFFF));
        send_transition(make_transition(6'd63, 2'd3, 6'd63, 2'd3, 32'h7FFF_FFFF));
        send_transition(make_transition(6'd0,  2'd1, 6'd63, 2'd0, 32'h8000_0000));
        send_transition(make_transition(6'd1,  2'd2, 6'd0,  2'd1, 32'hFFFF_FFFF));

        // Alpha and gamma at one: the target saturates high
        wait_for_results();
        load_settings(COEF_ONE, COEF_ONE, MODE_QLEARN);
        send_transition(make_transition(6'd5, 2'd0, 6'd5, 2'd2, 32'h7FFF_FFFF));
        send_transition(make_transition(6'd5, 2'd1, 6'd5, 2'd1, 32'h7FFF_FFFF));
        send_transition(make_transition(6'd5, 2'd0, 6'd5, 2'd3, 32'h8000_0000));
        send_transition(make_transition(6'd8, 2'd3, 6'd5, 2'd0, 32'h0001_8000));

        // Coefficients above one, SARSA: the target saturates low, next action used
        wait_for_results();
        load_settings(17'h1FFFF, 17'h1FFFF, MODE_SARSA);
        send_transition(make_transition(6'd6,  2'd0, 6'd7, 2'd2, 32'h8000_0000));
        send_transition(make_transition(6'd6,  2'd1, 6'd6, 2'd0, 32'h8000_0000));
        send_transition(make_transition(6'd9,  2'd3, 6'd6, 2'd1, 32'h0000_3039));
        send_transition(make_transition(6'd2,  2'd2, 6'd2, 2'd2, 32'h0001_0000));
        send_transition(make_transition(6'd62, 2'd1, 6'd5, 2'd1, 32'hFFFE_0000));

        // Alpha and gamma at zero: the table holds, the sum keeps adding
        wait_for_results();
        load_settings(17'd0, 17'd0, MODE_QLEARN);
        send_transition(make_transition(6'd3, 2'd0, 6'd5, 2'd0, 32'h7FFF_FFFF));
        send_transition(make_transition(6'd5, 2'd2, 6'd5, 2'd2, 32'hFFFF_0000));
        send_transition(make_transition(6'd6, 2'd0, 6'd6, 2'd3, 32'h8000_0000));

        // Random phases, each with its own coefficients and receiver behavior
        for (int p = 0; p < 6; p++) begin
            wait_for_results();
            case (p)
                0: load_settings(COEF_ONE, COEF_ONE, MODE_QLEARN);
                1: load_settings(17'd16384, 17'd0, MODE_SARSA);
                2: load_settings(17'h1FFFF, 17'h1FFFF, MODE_SARSA);
                3: load_settings(17'd32768, 17'd58982, MODE_QLEARN);
                4: load_settings(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                                 1'($urandom_range(0, 1)));
                default: load_settings(17'd65537, 17'd1, MODE_SARSA);
            endcase
            rx_style = rx_style_e'(p % 3);
            send_random(200);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending_count() != 0)
            $display("%0d results never arrived", board.pending_count());
        if (board.mismatches == 0 && board.pending_count() == 0) begin
            $display("q_table_update_engine_tb passed");
        end else begin
            $display("q_table_update_engine_tb failed");
        end
        $finish;
    end

endmodule
